@@ sv/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

@@ sv/tcarow_pkg.sv @@
// shared types, constants and functions of the totalistic row step unit
`default_nettype none

package tcarow_pkg;

   localparam int MAX_WIDTH_DEF = 256;
   localparam int CELL_BITS_DEF = 4;

   localparam int OP_W        = 2;
   localparam int INDEX_W     = 8;
   localparam int CELL_OUT_W  = 4;
   localparam int LEN_OUT_W   = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int SUM_W       = 6;
   localparam int RULE_FLAT_W = 3 * CSR_DATA_W;

   localparam logic [CSR_DATA_W-1:0] RULE_LOW_RESET  = 64'd4600172576;
   localparam logic [CSR_DATA_W-1:0] RULE_MID_RESET  = 64'd0;
   localparam logic [CSR_DATA_W-1:0] RULE_HIGH_RESET = 64'd0;

   typedef enum logic [OP_W-1:0] {
      OP_RESTART = 2'd0,
      OP_STEP    = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RULE_LOW  = 2'd0,
      CSR_RULE_MID  = 2'd1,
      CSR_RULE_HIGH = 2'd2
   } csr_idx_type;

   // commands from controller to datapath
   typedef struct packed {
      logic row_init;
      logic value_clear;
      logic step_clear;
      logic step_run;
      logic step_commit;
      logic read_issue;
      logic read_capture;
      logic rsp_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic step_done;
   } stat_type;

   // rule entry i sits at bit 4i of the concatenated rule words
   function automatic logic [3:0] rule_entry(input logic [RULE_FLAT_W-1:0] rules,
                                             input logic [SUM_W-1:0] sum);
      logic [7:0] bitpos;
      bitpos = {sum, 2'b00};
      return rules[bitpos +: 4];
   endfunction

endpackage

`default_nettype wire

@@ sv/tcarow_req_if.sv @@
// request channel interface
`default_nettype none

interface tcarow_req_if;
   logic                              valid;
   logic                              ready;
   logic [tcarow_pkg::OP_W-1:0]       opcode;
   logic [tcarow_pkg::INDEX_W-1:0]    cell_index;

   modport source (output valid, opcode, cell_index, input ready);
   modport sink   (input valid, opcode, cell_index, output ready);
endinterface

`default_nettype wire

@@ sv/tcarow_rsp_if.sv @@
// response channel interface
`default_nettype none

interface tcarow_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tcarow_pkg::CELL_OUT_W-1:0] cell_value;
   logic [tcarow_pkg::LEN_OUT_W-1:0]  row_length;
   logic                              at_limit;

   modport source (output valid, cell_value, row_length, at_limit, input ready);
   modport sink   (input valid, cell_value, row_length, at_limit, output ready);
endinterface

`default_nettype wire

@@ sv/tcarow_csr_if.sv @@
// configuration write channel interface
`default_nettype none

interface tcarow_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tcarow_pkg::CSR_IDX_W-1:0]  index;
   logic [tcarow_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/totalistic_ca_row_step_unit.sv @@
// a step streams the row through one memory read port, one cell per cycle
// one request in work at a time; the next is taken while a result waits
// reset: rule words take their defaults, then the init state writes the single
// starting cell before the first request is taken
`default_nettype none

module totalistic_ca_row_step_unit #(
   parameter int MAX_WIDTH = tcarow_pkg::MAX_WIDTH_DEF,
   parameter int CELL_BITS = tcarow_pkg::CELL_BITS_DEF
) (
   input wire logic     clock,
   input wire logic     reset,
   tcarow_req_if.sink   req_chan,
   tcarow_rsp_if.source rsp_chan,
   tcarow_csr_if.sink   csr_chan
);

   tcarow_pkg::cmd_type  cmd;
   tcarow_pkg::stat_type stat;
   logic                 req_ready, rsp_valid;

   tcarow_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcarow_dpath #(
      .MAX_WIDTH (MAX_WIDTH),
      .CELL_BITS (CELL_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cell_index (req_chan.cell_index),
      .csr_write      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .rsp_cell_value (rsp_chan.cell_value),
      .rsp_row_length (rsp_chan.row_length),
      .rsp_at_limit   (rsp_chan.at_limit)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign csr_chan.ready = 1'b1;

endmodule

`default_nettype wire

@@ sv/tcarow_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module tcarow_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/tcarow_ctrl.sv @@
// controller state machine of the row step unit
`default_nettype none

module tcarow_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [tcarow_pkg::OP_W-1:0] req_opcode,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire tcarow_pkg::stat_type        stat,
   output tcarow_pkg::cmd_type              cmd
);

   typedef enum logic [4:0] {
      ST_INIT = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_STEP = 5'b00100,
      ST_READ = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.row_init = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  tcarow_pkg::OP_RESTART: begin
                     cmd.row_init    = 1'b1;
                     cmd.value_clear = 1'b1;
                     state_in        = ST_DONE;
                  end
                  tcarow_pkg::OP_STEP: begin
                     cmd.step_clear  = 1'b1;
                     cmd.value_clear = 1'b1;
                     state_in        = ST_STEP;
                  end
                  tcarow_pkg::OP_READ: begin
                     cmd.read_issue = 1'b1;
                     state_in       = ST_READ;
                  end
                  default: begin
                     cmd.value_clear = 1'b1;
                     state_in        = ST_DONE;
                  end
               endcase
            end
         end
         ST_STEP: begin
            cmd.step_run = 1'b1;
            if (stat.step_done) begin
               cmd.step_commit = 1'b1;
               state_in        = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ sv/tcarow_dpath.sv @@
// datapath: row memory, sliding neighbor window, rule lookup, registers
`default_nettype none

module tcarow_dpath #(
   parameter int MAX_WIDTH = tcarow_pkg::MAX_WIDTH_DEF,
   parameter int CELL_BITS = tcarow_pkg::CELL_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tcarow_pkg::cmd_type               cmd,
   output tcarow_pkg::stat_type                   stat,
   input  wire logic [tcarow_pkg::INDEX_W-1:0]    req_cell_index,
   input  wire logic                              csr_write,
   input  wire logic [tcarow_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tcarow_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [tcarow_pkg::CELL_OUT_W-1:0]      rsp_cell_value,
   output logic [tcarow_pkg::LEN_OUT_W-1:0]       rsp_row_length,
   output logic                                   rsp_at_limit
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int LW = $clog2(MAX_WIDTH + 1);
   localparam int CW = $clog2(MAX_WIDTH + 2);
   localparam int IW = (LW > tcarow_pkg::INDEX_W) ? LW : tcarow_pkg::INDEX_W;
   localparam int SW = tcarow_pkg::SUM_W;

   logic [tcarow_pkg::CSR_DATA_W-1:0] rule_low_ff, rule_mid_ff, rule_high_ff;
   logic [LW-1:0]        len_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 dvalid_ff;
   logic [CELL_BITS-1:0] win_a_ff, win_b_ff;
   logic [CELL_BITS-1:0] value_ff;
   logic [tcarow_pkg::CELL_OUT_W-1:0] cell_out_ff;
   logic [tcarow_pkg::LEN_OUT_W-1:0]  len_out_ff;
   logic                              limit_out_ff;

   logic [LW-1:0]        next_len;
   logic                 at_limit;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [CELL_BITS-1:0] wr_data, rd_data, cell_in, left_cell;
   logic [SW-1:0]        nbr_sum;
   logic [3:0]           entry;
   logic                 idx_in_row, cnt_in_row;
   logic [CW-1:0]        wr_pos;

   assign at_limit   = (len_ff == LW'(MAX_WIDTH));
   assign next_len   = at_limit ? len_ff : len_ff + LW'(1);
   assign stat.step_done = (cnt_ff == CW'(next_len) + CW'(1));

   assign idx_in_row = (IW'(req_cell_index) < IW'(len_ff));
   assign cnt_in_row = (cnt_ff < CW'(len_ff));

   assign rd_en   = (cmd.read_issue & idx_in_row) | (cmd.step_run & cnt_in_row);
   assign rd_addr = cmd.read_issue ? AW'(req_cell_index) : cnt_ff[AW-1:0];

   // cells past the end of the row read as zero
   assign cell_in = dvalid_ff ? rd_data : '0;

   // mirror at the left edge when producing new cell 0
   assign left_cell = (cnt_ff == CW'(2)) ? cell_in : win_a_ff;
   assign nbr_sum   = SW'(left_cell) + SW'(win_b_ff) + SW'(cell_in);
   assign entry     = tcarow_pkg::rule_entry({rule_high_ff, rule_mid_ff, rule_low_ff},
                                             nbr_sum);

   assign wr_pos  = cnt_ff - CW'(2);
   assign wr_en   = cmd.row_init | (cmd.step_run & (cnt_ff >= CW'(2)));
   assign wr_addr = cmd.row_init ? '0 : wr_pos[AW-1:0];
   assign wr_data = cmd.row_init ? CELL_BITS'(1) : entry[CELL_BITS-1:0];

   tcarow_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_low_ff  <= tcarow_pkg::RULE_LOW_RESET;
         rule_mid_ff  <= tcarow_pkg::RULE_MID_RESET;
         rule_high_ff <= tcarow_pkg::RULE_HIGH_RESET;
         len_ff       <= LW'(1);
         cnt_ff       <= '0;
         dvalid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               tcarow_pkg::CSR_RULE_LOW:  rule_low_ff  <= csr_data;
               tcarow_pkg::CSR_RULE_MID:  rule_mid_ff  <= csr_data;
               tcarow_pkg::CSR_RULE_HIGH: rule_high_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.row_init) begin
            len_ff <= LW'(1);
         end else if (cmd.step_commit) begin
            len_ff <= next_len;
         end
         if (cmd.step_clear) begin
            cnt_ff <= '0;
         end else if (cmd.step_run) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         dvalid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_run && cnt_ff != '0) begin
         win_a_ff <= win_b_ff;
         win_b_ff <= cell_in;
      end
      if (cmd.value_clear) begin
         value_ff <= '0;
      end else if (cmd.read_capture) begin
         value_ff <= cell_in;
      end
      if (cmd.rsp_load) begin
         cell_out_ff  <= tcarow_pkg::CELL_OUT_W'(value_ff);
         len_out_ff   <= tcarow_pkg::LEN_OUT_W'(len_ff);
         limit_out_ff <= at_limit;
      end
   end

   assign rsp_cell_value = cell_out_ff;
   assign rsp_row_length = len_out_ff;
   assign rsp_at_limit   = limit_out_ff;

endmodule

`default_nettype wire

@@ sv/tcarow_chk.sv @@
// port level checker for the row step unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module tcarow_chk #(
   parameter int MAX_WIDTH = tcarow_pkg::MAX_WIDTH_DEF
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic [tcarow_pkg::OP_W-1:0]         req_opcode,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [tcarow_pkg::CELL_OUT_W-1:0]   rsp_cell_value,
   input wire logic [tcarow_pkg::LEN_OUT_W-1:0]    rsp_row_length,
   input wire logic                                rsp_at_limit
);

   logic                        push, pop;
   logic [1:0]                  cnt_ff, cnt_in;
   logic [tcarow_pkg::OP_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic                        head_live;

   assign push = req_valid & req_ready;
   assign pop  = rsp_valid & rsp_ready;

   // opcodes of requests whose responses are still owed, oldest first
   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd0) begin
            head_in = req_opcode;
         end else begin
            tail_in = req_opcode;
         end
      end else if (pop && !push) begin
         cnt_in  = (cnt_ff == 2'd0) ? 2'd0 : cnt_ff - 2'd1;
         head_in = tail_ff;
      end else if (pop && push) begin
         if (cnt_ff == 2'd1) begin
            head_in = req_opcode;
         end else begin
            head_in = tail_ff;
            tail_in = req_opcode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign head_live = rsp_valid && (cnt_ff != 2'd0);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) && $stable(rsp_row_length) && $stable(rsp_at_limit))
   `ASSERT_CLK(a_limit_len, clock, reset, rsp_valid && rsp_at_limit |-> rsp_row_length == tcarow_pkg::LEN_OUT_W'(MAX_WIDTH))
   `ASSERT_NEVER(a_value_only_read, clock, reset, head_live && head_ff != tcarow_pkg::OP_READ && rsp_cell_value != '0)
   `ASSERT_CLK(a_restart_len, clock, reset, head_live && head_ff == tcarow_pkg::OP_RESTART |-> rsp_row_length == tcarow_pkg::LEN_OUT_W'(1) && !rsp_at_limit)

endmodule

bind totalistic_ca_row_step_unit tcarow_chk #(
   .MAX_WIDTH (MAX_WIDTH)
) u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_opcode     (req_chan.opcode),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_cell_value (rsp_chan.cell_value),
   .rsp_row_length (rsp_chan.row_length),
   .rsp_at_limit   (rsp_chan.at_limit)
);

`default_nettype wire

@@ test/totalistic_ca_row_step_unit_test.sv @@
// testbench for the totalistic row step unit: directed and random requests
module totalistic_ca_row_step_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_MAX = tcarow_pkg::MAX_WIDTH_DEF;
   localparam logic [tcarow_pkg::CELL_OUT_W-1:0] CELL_MASK =
      tcarow_pkg::CELL_OUT_W'((1 << tcarow_pkg::CELL_BITS_DEF) - 1);
   localparam logic [tcarow_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int TOTAL_TARGET = 1200;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [tcarow_pkg::CELL_OUT_W-1:0] cell_value;
      logic [tcarow_pkg::LEN_OUT_W-1:0]  row_length;
      logic                              at_limit;
   } cell_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcarow_req_if req_bus ();
   tcarow_rsp_if rsp_bus ();
   tcarow_csr_if csr_bus ();

   totalistic_ca_row_step_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predicted row and rule table
   logic [tcarow_pkg::CELL_OUT_W-1:0] row_now [ROW_MAX];
   int unsigned                       row_len;
   logic [tcarow_pkg::CSR_DATA_W-1:0] rule_bank [3];
   cell_report_type                   awaited_rsp [$];

   int     requests_sent = 0;
   int     restarts_seen = 0;
   int     steps_seen = 0;
   int     reads_seen = 0;
   int     unused_seen = 0;
   int     rule_writes = 0;
   int     widest_row = 0;
   int     limit_hits = 0;
   int     responses_checked = 0;
   int     mismatches = 0;
   longint cycle_count = 0;
   bit     req_held = 1'b0;
   bit     csr_held = 1'b0;
   bit     req_steady = 1'b0;
   bit     rsp_steady = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void restart_row();
      foreach (row_now[i]) row_now[i] = '0;
      row_now[0] = 4'd1;
      row_len = 1;
   endfunction

   // mirrored at the left edge, zero at and past the end
   function automatic logic [tcarow_pkg::CELL_OUT_W-1:0] cell_at(int pos);
      if (pos < 0) pos = -pos;
      if (pos >= int'(row_len) || pos >= ROW_MAX) return '0;
      return row_now[pos];
   endfunction

   function automatic cell_report_type take_request(logic [tcarow_pkg::OP_W-1:0] op,
                                                    logic [tcarow_pkg::INDEX_W-1:0] idx);
      logic [tcarow_pkg::CELL_OUT_W-1:0] fresh [ROW_MAX];
      logic [tcarow_pkg::CSR_DATA_W-1:0] shifted;
      int unsigned                       grown;
      int                                sum;
      cell_report_type                   rep;
      rep.cell_value = '0;
      case (op)
         tcarow_pkg::OP_RESTART: begin
            restart_row();
            restarts_seen++;
         end
         tcarow_pkg::OP_STEP: begin
            grown = (row_len < ROW_MAX) ? row_len + 1 : ROW_MAX;
            foreach (fresh[i]) fresh[i] = '0;
            for (int k = 0; k < int'(grown); k++) begin
               sum = int'(cell_at(k - 1)) + int'(cell_at(k)) + int'(cell_at(k + 1));
               shifted = rule_bank[sum / 16] >> (4 * (sum % 16));
               fresh[k] = shifted[tcarow_pkg::CELL_OUT_W-1:0] & CELL_MASK;
            end
            row_now = fresh;
            row_len = grown;
            steps_seen++;
         end
         tcarow_pkg::OP_READ: begin
            if (idx < row_len && idx < ROW_MAX) rep.cell_value = row_now[idx];
            reads_seen++;
         end
         default: unused_seen++;
      endcase
      rep.row_length = row_len[tcarow_pkg::LEN_OUT_W-1:0];
      rep.at_limit = (row_len >= ROW_MAX);
      if (int'(row_len) > widest_row) widest_row = int'(row_len);
      if (rep.at_limit) limit_hits++;
      return rep;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic [tcarow_pkg::CSR_DATA_W-1:0] random_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_request(input logic [tcarow_pkg::OP_W-1:0] op,
                               input logic [tcarow_pkg::INDEX_W-1:0] idx);
      int gap;
      gap = pick_gap(req_steady);
      if (csr_held) begin
         csr_bus.valid <= 1'b0;
         csr_held = 1'b0;
      end
      if (gap > 0 && req_held) begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.cell_index <= idx;
      req_held = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      awaited_rsp.push_back(take_request(op, idx));
      requests_sent++;
   endtask

   task automatic wait_for_idle();
      if (req_held) begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
      end
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_rule(input tcarow_pkg::csr_idx_type which,
                             input logic [tcarow_pkg::CSR_DATA_W-1:0] value);
      int gap;
      wait_for_idle();
      gap = pick_gap(1'b0);
      if (gap > 0 && csr_held) begin
         csr_bus.valid <= 1'b0;
         csr_held = 1'b0;
      end
      repeat (gap) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= which;
      csr_bus.data <= value;
      csr_held = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      rule_bank[which] = value;
      rule_writes++;
   endtask

   // restart, then a run of generations with reads and odd requests mixed in
   task automatic grow_sequence(input int steps, input int read_pct);
      int roll;
      send_request(tcarow_pkg::OP_RESTART, tcarow_pkg::INDEX_W'($urandom));
      repeat (steps) begin
         send_request(tcarow_pkg::OP_STEP, tcarow_pkg::INDEX_W'($urandom));
         roll = $urandom_range(0, 99);
         if (roll < read_pct)
            send_request(tcarow_pkg::OP_READ,
                         tcarow_pkg::INDEX_W'($urandom_range(0, row_len - 1)));
         else if (roll < read_pct + 3)
            send_request(tcarow_pkg::OP_READ, tcarow_pkg::INDEX_W'($urandom));
         else if (roll < read_pct + 4 && row_len < ROW_MAX)
            send_request(tcarow_pkg::OP_READ, tcarow_pkg::INDEX_W'(row_len));
         else if (roll < read_pct + 6)
            send_request(OP_UNUSED, tcarow_pkg::INDEX_W'($urandom));
      end
   endtask

   task automatic test_reset_and_opcodes();
      send_request(tcarow_pkg::OP_READ, 8'h00);
      send_request(tcarow_pkg::OP_READ, 8'h01);
      send_request(tcarow_pkg::OP_READ, 8'hFF);
      send_request(OP_UNUSED, 8'hAA);
      send_request(tcarow_pkg::OP_STEP, 8'h55);
      send_request(tcarow_pkg::OP_STEP, 8'hFF);
      send_request(tcarow_pkg::OP_READ, 8'h00);
      send_request(tcarow_pkg::OP_READ, 8'h01);
      send_request(tcarow_pkg::OP_READ, 8'h02);
      send_request(tcarow_pkg::OP_READ, 8'h03);
      send_request(tcarow_pkg::OP_STEP, 8'h00);
      send_request(tcarow_pkg::OP_READ, 8'h03);
      send_request(tcarow_pkg::OP_READ, 8'h04);
      send_request(OP_UNUSED, 8'h55);
      send_request(tcarow_pkg::OP_RESTART, 8'hFF);
      send_request(tcarow_pkg::OP_READ, 8'h00);
      send_request(tcarow_pkg::OP_READ, 8'h01);
      send_request(tcarow_pkg::OP_STEP, 8'hAA);
      send_request(tcarow_pkg::OP_READ, 8'h01);
   endtask

   // all ones reaches the top entries, all zeros kills the row, then random, then reset values
   task automatic test_rule_settings();
      logic [tcarow_pkg::CSR_DATA_W-1:0] words [3];
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            0: words = '{'1, '1, '1};
            1: words = '{'0, '0, '0};
            2: words = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
            default: words = '{tcarow_pkg::RULE_LOW_RESET, tcarow_pkg::RULE_MID_RESET,
                               tcarow_pkg::RULE_HIGH_RESET};
         endcase
         write_rule(tcarow_pkg::CSR_RULE_LOW, words[0]);
         write_rule(tcarow_pkg::CSR_RULE_MID, words[1]);
         write_rule(tcarow_pkg::CSR_RULE_HIGH, words[2]);
         grow_sequence(8, 50);
      end
   endtask

   task automatic test_row_limit();
      repeat (2) begin
         write_rule(tcarow_pkg::CSR_RULE_LOW, random_word());
         write_rule(tcarow_pkg::CSR_RULE_MID, random_word());
         write_rule(tcarow_pkg::CSR_RULE_HIGH, random_word());
         grow_sequence(ROW_MAX + 3, 8);
         send_request(tcarow_pkg::OP_READ, 8'hFF);
         send_request(tcarow_pkg::OP_READ, 8'hFE);
         send_request(tcarow_pkg::OP_STEP, tcarow_pkg::INDEX_W'($urandom));
         send_request(tcarow_pkg::OP_READ, 8'hFF);
      end
   endtask

   task automatic test_random_generations();
      while (requests_sent < TOTAL_TARGET) begin
         if ($urandom_range(0, 9) == 0)
            write_rule(tcarow_pkg::csr_idx_type'($urandom_range(0, 2)), random_word());
         req_steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 80)
            grow_sequence(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 30), 35);
         else
            repeat ($urandom_range(1, 8))
               send_request(tcarow_pkg::OP_W'($urandom_range(0, 3)),
                            tcarow_pkg::INDEX_W'($urandom));
      end
      req_steady = 1'b0;
   endtask

   // response back-pressure with quiet stretches
   initial begin
      int hold;
      int stretch;
      int gap;
      hold = 0;
      stretch = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            rsp_steady = ($urandom_range(0, 4) == 0);
            stretch = $urandom_range(50, 400);
         end else begin
            stretch--;
         end
         if (hold > 0) begin
            hold--;
         end else begin
            gap = pick_gap(rsp_steady);
            if (gap == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               hold = gap - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cell_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_checked++;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d with no request outstanding: value %0d len %0d lim %0b",
                        responses_checked, rsp_bus.cell_value, rsp_bus.row_length,
                        rsp_bus.at_limit);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_bus.cell_value !== want.cell_value ||
                rsp_bus.row_length !== want.row_length ||
                rsp_bus.at_limit !== want.at_limit) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"response %0d mismatch: expected value %0d len %0d lim %0b,",
                            " got value %0d len %0d lim %0b"},
                           responses_checked, want.cell_value, want.row_length,
                           want.at_limit, rsp_bus.cell_value, rsp_bus.row_length,
                           rsp_bus.at_limit);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", awaited_rsp.size());
         $display("totalistic_ca_row_step_unit_test failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = tcarow_pkg::OP_RESTART;
      req_bus.cell_index = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = tcarow_pkg::CSR_RULE_LOW;
      csr_bus.data = '0;
      rule_bank[tcarow_pkg::CSR_RULE_LOW] = tcarow_pkg::RULE_LOW_RESET;
      rule_bank[tcarow_pkg::CSR_RULE_MID] = tcarow_pkg::RULE_MID_RESET;
      rule_bank[tcarow_pkg::CSR_RULE_HIGH] = tcarow_pkg::RULE_HIGH_RESET;
      restart_row();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_and_opcodes();
      test_rule_settings();
      test_row_limit();
      test_random_generations();

      wait_for_idle();
      if (csr_held) begin
         csr_bus.valid <= 1'b0;
         csr_held = 1'b0;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d restarts, %0d generations, %0d reads, %0d unused",
               requests_sent, restarts_seen, steps_seen, reads_seen, unused_seen);
      $display("%0d rule writes, widest row %0d, %0d responses at the limit, %0d mismatches",
               rule_writes, widest_row, limit_hits, mismatches);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("totalistic_ca_row_step_unit_test passed");
      end else begin
         $display("totalistic_ca_row_step_unit_test failed");
      end
      $finish;
   end

endmodule
